// ===== rtl/aagv_pkg.sv =====
// ----------------------------------------------------------------------------
// aagv_pkg
// Shared types and constants for the absolute angle glitch validator.
// ----------------------------------------------------------------------------
package aagv_pkg;

    // Configuration port widths
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 14;

    // Register field widths
    localparam int OFFSET_BITS = 14;
    localparam int JUMP_BITS   = 14;
    localparam int COUNT_BITS  = 8;

    // Register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ZERO_OFFSET      = 4'd0,
        CFG_INVERT_DIRECTION = 4'd1,
        CFG_MAX_JUMP         = 4'd2,
        CFG_VALIDATION_COUNT = 4'd3
    } t_cfg_index;

    // Command codes
    typedef enum logic {
        CMD_SAMPLE    = 1'b0,
        CMD_REACQUIRE = 1'b1
    } t_command;

    // Register reset values
    localparam logic [OFFSET_BITS-1:0] RST_ZERO_OFFSET      = '0;
    localparam logic                   RST_INVERT_DIRECTION = 1'b0;
    localparam logic [JUMP_BITS-1:0]   RST_MAX_JUMP         = 14'd91;
    localparam logic [COUNT_BITS-1:0]  RST_VALIDATION_COUNT = 8'd3;

endpackage

// ===== rtl/absolute_angle_glitch_validator.sv =====
// ----------------------------------------------------------------------------
// absolute_angle_glitch_validator
// Offset, direction and wrap of absolute encoder samples, with lock-in and
// jump rejection of the tracked axis position.
// ----------------------------------------------------------------------------
// A sample goes through the input register, then the result register;
//   a reacquire gives no result. Throughput: one request per cycle unless the
//   output stalls while a sample waits; the state update is a single pass of logic
//   between the input register and the result register.
// Reset: synchronous, active low; clears lock state, both stages and restores
//   register defaults. Configuration is taken every cycle.
module absolute_angle_glitch_validator #(
    parameter int ANGLE_BITS = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [aagv_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [aagv_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    // sample requests
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_command,
    input  logic [ANGLE_BITS-1:0]               i_raw_angle,
    input  logic                                i_sensor_error,
    // results
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [ANGLE_BITS-1:0]        o_position,
    output logic                                o_position_valid,
    output logic                                o_locked
);

    localparam int A  = ANGLE_BITS;
    localparam int SW = ANGLE_BITS + 1;
    // compare width: covers the step magnitude and the jump register
    localparam int CW = ((ANGLE_BITS > aagv_pkg::JUMP_BITS) ?
                         ANGLE_BITS : aagv_pkg::JUMP_BITS) + 1;
    localparam int CB = aagv_pkg::COUNT_BITS;
    localparam logic signed [SW-1:0] HALF_S = SW'(1) <<< (A - 1);
    localparam logic signed [SW-1:0] TURN_S = SW'(1) <<< A;

    // configuration registers
    logic [aagv_pkg::OFFSET_BITS-1:0] r_zero_offset;
    logic                             r_invert;
    logic [aagv_pkg::JUMP_BITS-1:0]   r_max_jump;
    logic [CB-1:0]                    r_vcount;

    // input stage
    logic                 r_in_valid;
    logic                 r_in_cmd;
    logic [A-1:0]         r_in_raw;
    logic                 r_in_err;

    // tracking state
    logic signed [A-1:0]  r_held;
    logic signed [A-1:0]  r_cand;
    logic                 r_lock;
    logic [CB-1:0]        r_count;

    // result stage
    logic                 r_out_valid;
    logic signed [A-1:0]  r_pos;
    logic                 r_pos_valid;
    logic                 r_out_lock;

    // next values
    logic signed [A-1:0]  n_held;
    logic signed [A-1:0]  n_cand;
    logic                 n_lock;
    logic [CB-1:0]        n_count;
    logic signed [A-1:0]  n_pos;
    logic                 n_pos_valid;

    logic                 adv;
    logic                 is_sample;
    logic [A-1:0]         offset_a;
    logic [A-1:0]         diff;
    logic signed [A-1:0]  meas;
    logic signed [A-1:0]  step_ref;
    logic signed [SW-1:0] step;
    logic signed [SW-1:0] step_w;
    logic [SW-1:0]        step_abs;
    logic                 step_ok;
    logic [CB-1:0]        count_inc;

    assign o_cfg_ready = 1'b1;

    // ---- configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset <= aagv_pkg::RST_ZERO_OFFSET;
            r_invert      <= aagv_pkg::RST_INVERT_DIRECTION;
            r_max_jump    <= aagv_pkg::RST_MAX_JUMP;
            r_vcount      <= aagv_pkg::RST_VALIDATION_COUNT;
        end else if (i_cfg_valid) begin
            unique case (aagv_pkg::t_cfg_index'(i_cfg_index))
                aagv_pkg::CFG_ZERO_OFFSET: begin
                    r_zero_offset <= i_cfg_data[aagv_pkg::OFFSET_BITS-1:0];
                end
                aagv_pkg::CFG_INVERT_DIRECTION: begin
                    r_invert <= i_cfg_data[0];
                end
                aagv_pkg::CFG_MAX_JUMP: begin
                    r_max_jump <= i_cfg_data[aagv_pkg::JUMP_BITS-1:0];
                end
                aagv_pkg::CFG_VALIDATION_COUNT: begin
                    r_vcount <= i_cfg_data[CB-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---- handshake: a reacquire never needs the result stage
    assign is_sample  = (aagv_pkg::t_command'(r_in_cmd) == aagv_pkg::CMD_SAMPLE);
    assign adv        = r_in_valid && (!is_sample || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;

    // ---- input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_cmd <= i_command;
            r_in_raw <= i_raw_angle;
            r_in_err <= i_sensor_error;
        end
    end

    // ---- measured position: offset, optional negate, wrap by two's complement
    always_comb begin
        offset_a = A'({{CW{1'b0}}, r_zero_offset});
        diff     = r_in_raw - offset_a;
        if (r_invert) begin
            diff = A'(0) - diff;
        end
        meas = signed'(diff);
    end

    // ---- wrapped step against held or candidate position
    always_comb begin
        step_ref = r_lock ? r_held : r_cand;
        step     = SW'(meas) - SW'(step_ref);
        step_w   = step;
        if (step > HALF_S) begin
            step_w = step - TURN_S;
        end else if (step < -HALF_S) begin
            step_w = step + TURN_S;
        end
        step_abs = step_w[SW-1] ? unsigned'(-step_w) : unsigned'(step_w);
        step_ok  = (CW'(step_abs) <= CW'(r_max_jump));
    end

    assign count_inc = r_count + CB'(1);

    // ---- tracking update
    always_comb begin
        n_held      = r_held;
        n_cand      = r_cand;
        n_lock      = r_lock;
        n_count     = r_count;
        n_pos       = meas;
        n_pos_valid = 1'b0;
        if (!is_sample) begin
            n_lock  = 1'b0;
            n_count = '0;
        end else if (r_in_err) begin
            // error: hold when locked, else restart acquisition
            if (r_lock) begin
                n_pos = r_held;
            end else begin
                n_count = '0;
            end
        end else if (!r_lock) begin
            // acquisition
            n_count = (r_count == '0 || !step_ok) ? CB'(1) : count_inc;
            n_cand  = meas;
            if (n_count >= r_vcount) begin
                n_held      = meas;
                n_lock      = 1'b1;
                n_count     = '0;
                n_pos_valid = 1'b1;
            end
        end else begin
            // tracking with jump rejection
            if (step_ok) begin
                n_held      = meas;
                n_pos_valid = 1'b1;
            end
            n_pos = step_ok ? meas : r_held;
        end
    end

    // ---- state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_cand  <= '0;
            r_lock  <= 1'b0;
            r_count <= '0;
        end else if (adv) begin
            r_held  <= n_held;
            r_cand  <= n_cand;
            r_lock  <= n_lock;
            r_count <= n_count;
        end
    end

    // ---- result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && is_sample) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && is_sample) begin
            r_pos       <= n_pos;
            r_pos_valid <= n_pos_valid;
            r_out_lock  <= n_lock;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_position       = r_pos;
    assign o_position_valid = r_pos_valid;
    assign o_locked         = r_out_lock;

    // ---- assertions
    // lock only comes from an error-free sample
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_lock) |-> $past(adv && is_sample && !r_in_err))
        else $error("lock set without a good sample");

    // acquisition counter is idle while locked
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lock |-> (r_count == '0))
        else $error("coherent count active while locked");

    // a valid position always reports lock
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_position_valid) |-> o_locked)
        else $error("valid position without lock");

    // a reacquire passing while the output is stalled leaves the result alone
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !is_sample && o_out_valid && i_out_stall)
            |=> (o_out_valid && $stable(o_position) && $stable(o_locked)))
        else $error("reacquire disturbed a pending result");

    // reset empties both stages
    assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !r_in_valid && !r_lock))
        else $error("stages not empty after reset");

endmodule

// ===== tb/sv/absolute_angle_glitch_validator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// absolute_angle_glitch_validator_tb
// Self-checking bench for the absolute angle glitch validator. A scoreboard
// class tracks offset, direction, wrap, lock-in and jump rejection of every
// accepted request and checks each result in order. Stimulus is a directed
// set followed by random bursts of coherent motion mixed with glitches,
// sensor errors and reacquire requests, under several register settings and
// with random idling and stalls on both sides.
// ----------------------------------------------------------------------------
module absolute_angle_glitch_validator_tb;

    localparam int ANGLE_BITS  = 14;
    localparam int TURN        = 1 << ANGLE_BITS;
    localparam int HALF        = 1 << (ANGLE_BITS - 1);
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 4;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] position;
        logic                  position_valid;
        logic                  locked;
    } t_angle_result;

    // Tracks the axis position the block should report and checks results
    class angle_scoreboard;
        logic [aagv_pkg::OFFSET_BITS-1:0] zero_offset;
        logic                             invert_dir;
        logic [aagv_pkg::JUMP_BITS-1:0]   max_jump;
        logic [aagv_pkg::COUNT_BITS-1:0]  lock_count;

        logic [ANGLE_BITS-1:0]            held_pos;
        logic [ANGLE_BITS-1:0]            cand_pos;
        logic [aagv_pkg::COUNT_BITS-1:0]  coherent;
        bit                               have_lock;
        bit                               valid_flag;

        t_angle_result          positions_q[$];
        int                     mismatches;
        int                     n_requests;
        int                     n_reacquire;
        int                     n_errors;
        int                     n_checked;
        int                     n_locked;
        int                     n_rejected;

        function new();
            zero_offset = aagv_pkg::RST_ZERO_OFFSET;
            invert_dir  = aagv_pkg::RST_INVERT_DIRECTION;
            max_jump    = aagv_pkg::RST_MAX_JUMP;
            lock_count  = aagv_pkg::RST_VALIDATION_COUNT;
            held_pos    = '0;
            cand_pos    = '0;
            coherent    = '0;
            have_lock   = 1'b0;
            valid_flag  = 1'b0;
        endfunction

        function void write_reg(aagv_pkg::t_cfg_index idx,
                                logic [aagv_pkg::CFG_DATA_BITS-1:0] data);
            case (idx)
                aagv_pkg::CFG_ZERO_OFFSET:
                    zero_offset = data[aagv_pkg::OFFSET_BITS-1:0];
                aagv_pkg::CFG_INVERT_DIRECTION:
                    invert_dir  = data[0];
                aagv_pkg::CFG_MAX_JUMP:
                    max_jump    = data[aagv_pkg::JUMP_BITS-1:0];
                aagv_pkg::CFG_VALIDATION_COUNT:
                    lock_count  = data[aagv_pkg::COUNT_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Offset, optional negate; the 14-bit two's complement is the wrap
        function logic [ANGLE_BITS-1:0] measure(logic [ANGLE_BITS-1:0] raw);
            logic [ANGLE_BITS-1:0] d;
            d = raw - zero_offset[ANGLE_BITS-1:0];
            if (invert_dir)
                d = -d;
            return d;
        endfunction

        // Wrapped step within the jump limit; a step of exactly half a turn stays
        function bit step_in_limit(logic [ANGLE_BITS-1:0] m, logic [ANGLE_BITS-1:0] anchor);
            int d;
            d = int'($signed(m)) - int'($signed(anchor));
            if (d > HALF)
                d -= TURN;
            else if (d < -HALF)
                d += TURN;
            return (d <= int'(max_jump)) && (d >= -int'(max_jump));
        endfunction

        function void note_request(aagv_pkg::t_command cmd, logic [ANGLE_BITS-1:0] raw,
                                   logic err);
            logic [ANGLE_BITS-1:0] m;
            logic [ANGLE_BITS-1:0] pos;
            n_requests++;
            if (cmd == aagv_pkg::CMD_REACQUIRE) begin
                have_lock  = 1'b0;
                valid_flag = 1'b0;
                coherent   = '0;
                n_reacquire++;
                return;
            end
            m = measure(raw);
            if (err) begin
                n_errors++;
                valid_flag = 1'b0;
                if (!have_lock)
                    coherent = '0;
                pos = have_lock ? held_pos : m;
            end else if (!have_lock) begin
                // acquisition: count coherent samples until the lock count
                if (coherent == 0 || !step_in_limit(m, cand_pos))
                    coherent = 1;
                else
                    coherent = coherent + 1'b1;
                cand_pos = m;
                if (coherent >= lock_count) begin
                    held_pos   = cand_pos;
                    have_lock  = 1'b1;
                    valid_flag = 1'b1;
                    coherent   = '0;
                    pos        = held_pos;
                end else begin
                    valid_flag = 1'b0;
                    pos        = m;
                end
            end else begin
                // locked: reject glitches, hold last good position
                if (!step_in_limit(m, held_pos)) begin
                    valid_flag = 1'b0;
                    n_rejected++;
                end else begin
                    held_pos   = m;
                    valid_flag = 1'b1;
                end
                pos = held_pos;
            end
            positions_q.push_back('{position: pos, position_valid: valid_flag,
                                    locked: have_lock});
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 100)
                $display("MISMATCH: %s", msg);
        endtask

        task check_result(logic [ANGLE_BITS-1:0] pos, logic pos_valid, logic lk);
            t_angle_result want;
            if (positions_q.size() == 0) begin
                report($sformatf("result with nothing pending: position %0d valid %0b locked %0b",
                                 $signed(pos), pos_valid, lk));
                return;
            end
            want = positions_q.pop_front();
            n_checked++;
            if (lk === 1'b1)
                n_locked++;
            if (pos !== want.position)
                report($sformatf("result %0d: position %0d, want %0d",
                                 n_checked, $signed(pos), $signed(want.position)));
            if (pos_valid !== want.position_valid)
                report($sformatf("result %0d: position_valid %0b, want %0b",
                                 n_checked, pos_valid, want.position_valid));
            if (lk !== want.locked)
                report($sformatf("result %0d: locked %0b, want %0b",
                                 n_checked, lk, want.locked));
        endtask

        function int pending();
            return positions_q.size();
        endfunction
    endclass

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_cfg_valid;
    logic                                 o_cfg_ready;
    logic [aagv_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index;
    logic [aagv_pkg::CFG_DATA_BITS-1:0]   i_cfg_data;
    logic                                 i_in_valid;
    logic                                 o_in_stall;
    logic                                 i_command;
    logic [ANGLE_BITS-1:0]                i_raw_angle;
    logic                                 i_sensor_error;
    logic                                 o_out_valid;
    logic                                 i_out_stall;
    logic signed [ANGLE_BITS-1:0]         o_position;
    logic                                 o_position_valid;
    logic                                 o_locked;

    angle_scoreboard       sb;
    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    stall_hold_cycles;
    int                    items_sent;
    int                    cycle_count;
    int                    cur_jump;
    int                    cur_count;
    logic [ANGLE_BITS-1:0] track;

    absolute_angle_glitch_validator #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_raw_angle      (i_raw_angle),
        .i_sensor_error   (i_sensor_error),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_position       (o_position),
        .o_position_valid (o_position_valid),
        .o_locked         (o_locked)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count, sb.pending());
            $display("absolute_angle_glitch_validator_tb: done, errors");
            $finish;
        end
    end

    // Result side: random stall, or a long hold-off when one is asked for
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_hold_cycles != 0) begin
                i_out_stall <= 1'b1;
                stall_hold_cycles--;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // Monitor: results are checked before the same edge's request is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_position, o_position_valid, o_locked);
            if (i_in_valid && !o_in_stall)
                sb.note_request(aagv_pkg::t_command'(i_command), i_raw_angle,
                                i_sensor_error);
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(aagv_pkg::t_cfg_index'(i_cfg_index), i_cfg_data);
        end
    end

    // One request; valid stays high on return so back-to-back requests need no gap
    task send_item(aagv_pkg::t_command cmd, logic [ANGLE_BITS-1:0] raw, logic err);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_raw_angle    <= raw;
        i_sensor_error <= err;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        items_sent++;
    endtask

    // Wait for every pending result, then let a reacquire settle
    task drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task write_reg(aagv_pkg::t_cfg_index idx, logic [aagv_pkg::CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
    endtask

    task configure(logic [aagv_pkg::OFFSET_BITS-1:0] offset, logic inv,
                   logic [aagv_pkg::JUMP_BITS-1:0] jump,
                   logic [aagv_pkg::COUNT_BITS-1:0] count);
        write_reg(aagv_pkg::CFG_ZERO_OFFSET, offset);
        write_reg(aagv_pkg::CFG_INVERT_DIRECTION, aagv_pkg::CFG_DATA_BITS'(inv));
        write_reg(aagv_pkg::CFG_MAX_JUMP, jump);
        write_reg(aagv_pkg::CFG_VALIDATION_COUNT, aagv_pkg::CFG_DATA_BITS'(count));
        i_cfg_valid <= 1'b0;
        cur_jump  = jump;
        cur_count = count;
    endtask

    // Move the tracked angle by a random step of at most lim counts
    task send_step(int lim);
        int mag;
        mag   = $urandom_range(0, lim);
        track = track + ANGLE_BITS'($urandom_range(0, 1) ? mag : -mag);
        send_item(aagv_pkg::CMD_SAMPLE, track, 1'b0);
    endtask

    // Enough coherent motion to lock, then a short run of disturbances
    task random_burst();
        int clean;
        int noise;
        int kind;
        int lim;
        int mag;
        lim   = (cur_jump > HALF) ? HALF : cur_jump;
        clean = cur_count + $urandom_range(0, 15);
        for (int k = 0; k < clean; k++)
            send_step($urandom_range(0, 1) ? lim : lim / 4);
        noise = $urandom_range(1, 8);
        for (int k = 0; k < noise; k++) begin
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                // one-off glitch, track unchanged
                send_item(aagv_pkg::CMD_SAMPLE, ANGLE_BITS'($urandom), 1'b0);
            end else if (kind < 40) begin
                // the axis really moved far away
                track = ANGLE_BITS'($urandom);
                send_item(aagv_pkg::CMD_SAMPLE, track, 1'b0);
            end else if (kind < 60) begin
                send_item(aagv_pkg::CMD_SAMPLE, ANGLE_BITS'($urandom), 1'b1);
            end else if (kind < 70) begin
                send_item(aagv_pkg::CMD_REACQUIRE, ANGLE_BITS'($urandom),
                          1'($urandom_range(0, 1)));
            end else begin
                // step right at or just past the jump limit
                mag   = cur_jump + $urandom_range(0, 1);
                track = track + ANGLE_BITS'($urandom_range(0, 1) ? mag : -mag);
                send_item(aagv_pkg::CMD_SAMPLE, track, 1'b0);
            end
        end
    endtask

    task run_phase(logic [aagv_pkg::OFFSET_BITS-1:0] offset, logic inv,
                   logic [aagv_pkg::JUMP_BITS-1:0] jump,
                   logic [aagv_pkg::COUNT_BITS-1:0] count, int n_items, int hold);
        int stop_at;
        drain();
        configure(offset, inv, jump, count);
        stall_hold_cycles = hold;
        track   = ANGLE_BITS'($urandom);
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
            random_burst();
    endtask

    // Stimulus
    initial begin
        sb                = new();
        i_rst_n           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = aagv_pkg::CFG_ZERO_OFFSET;
        i_cfg_data        = '0;
        i_in_valid        = 1'b0;
        i_command         = aagv_pkg::CMD_SAMPLE;
        i_raw_angle       = '0;
        i_sensor_error    = 1'b0;
        stall_hold_cycles = 0;
        items_sent        = 0;
        send_idle_pct     = 9;
        recv_idle_pct     = 72;
        cur_jump          = aagv_pkg::RST_MAX_JUMP;
        cur_count         = aagv_pkg::RST_VALIDATION_COUNT;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: lock after three, jump limit 91
        send_item(aagv_pkg::CMD_SAMPLE, 14'd0, 1'b0);
        send_item(aagv_pkg::CMD_SAMPLE, 14'd16383, 1'b0);      // step -1 across zero
        send_item(aagv_pkg::CMD_SAMPLE, 14'd0, 1'b0);          // third coherent: lock
        send_item(aagv_pkg::CMD_SAMPLE, 14'd91, 1'b0);         // exactly the limit
        send_item(aagv_pkg::CMD_SAMPLE, 14'd183, 1'b0);        // one past: rejected
        send_item(aagv_pkg::CMD_SAMPLE, 14'd0, 1'b0);          // -91 from held
        send_item(aagv_pkg::CMD_SAMPLE, 14'd8192, 1'b1);       // error while locked
        send_item(aagv_pkg::CMD_REACQUIRE, 14'd5555, 1'b1);    // payload ignored
        send_item(aagv_pkg::CMD_SAMPLE, 14'd8191, 1'b1);       // error before lock
        send_item(aagv_pkg::CMD_SAMPLE, 14'd8192, 1'b0);       // most negative position
        send_item(aagv_pkg::CMD_SAMPLE, 14'd8191, 1'b0);       // wrapped step of -1

        // Full offset, inverted, half-turn limit, lock on first sample
        drain();
        configure(14'd16383, 1'b1, 14'd8192, 8'd1);
        send_item(aagv_pkg::CMD_SAMPLE, 14'd0, 1'b0);
        send_item(aagv_pkg::CMD_SAMPLE, 14'd8191, 1'b0);
        send_item(aagv_pkg::CMD_SAMPLE, 14'd16383, 1'b0);      // step of exactly +half turn
        send_item(aagv_pkg::CMD_SAMPLE, 14'd8191, 1'b0);       // and back by -half turn

        // Zero jump limit and a lock count of zero
        drain();
        configure(14'd8192, 1'b0, 14'd0, 8'd0);
        send_item(aagv_pkg::CMD_SAMPLE, 14'd8192, 1'b0);
        send_item(aagv_pkg::CMD_SAMPLE, 14'd8192, 1'b0);
        send_item(aagv_pkg::CMD_SAMPLE, 14'd8193, 1'b0);
        send_item(aagv_pkg::CMD_SAMPLE, 14'd0, 1'b0);
        send_item(aagv_pkg::CMD_REACQUIRE, 14'd0, 1'b0);
        send_item(aagv_pkg::CMD_SAMPLE, 14'd1, 1'b1);
        send_item(aagv_pkg::CMD_SAMPLE, 14'd0, 1'b0);

        // Sender mostly busy, receiver mostly stalled
        run_phase(14'd0, 1'b0, 14'd91, 8'd3, 300, 0);
        run_phase(14'd16383, 1'b1, 14'd8192, 8'd1, 150, 0);
        run_phase(aagv_pkg::OFFSET_BITS'($urandom), 1'b0, 14'd0, 8'd1, 130, 0);

        // Sender mostly idle, receiver mostly ready
        send_idle_pct = 72;
        recv_idle_pct = 9;
        run_phase(aagv_pkg::OFFSET_BITS'($urandom), 1'b1, 14'd500, 8'd8, 300, 0);
        run_phase(14'd5000, 1'b0, 14'd8191, 8'd2, 150, 0);
        run_phase(aagv_pkg::OFFSET_BITS'($urandom), 1'b0, 14'd30, 8'd255, 270, 0);

        // No idling; the first phase opens with a long receiver hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(aagv_pkg::OFFSET_BITS'($urandom), 1'($urandom_range(0, 1)),
                  aagv_pkg::JUMP_BITS'($urandom_range(0, 8192)),
                  aagv_pkg::COUNT_BITS'($urandom_range(1, 12)),
                  300, 400);
        run_phase(14'd16383, 1'b0, 14'd1, 8'd1, 150, 0);

        drain();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        $display("covered %0d requests: %0d reacquire, %0d with sensor error, 11 register settings",
                 sb.n_requests, sb.n_reacquire, sb.n_errors);
        $display("checked %0d results, %0d while locked, %0d jumps rejected, %0d mismatches",
                 sb.n_checked, sb.n_locked, sb.n_rejected, sb.mismatches);
        if (sb.mismatches == 0)
            $display("absolute_angle_glitch_validator_tb: done, clean");
        else
            $display("absolute_angle_glitch_validator_tb: done, errors");
        $finish;
    end

endmodule

// ===== absolute_angle_glitch_validator.f =====
rtl/aagv_pkg.sv
rtl/absolute_angle_glitch_validator.sv
tb/sv/absolute_angle_glitch_validator_tb.sv
